### sv/perspective_projection_matrix_unit_macros.svh
// assertion macros for the projection matrix port checks
`ifndef PERSPECTIVE_PROJECTION_MATRIX_UNIT_MACROS_SVH
`define PERSPECTIVE_PROJECTION_MATRIX_UNIT_MACROS_SVH

// same-cycle implication, idle while reset is low
`define PPM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("projection matrix port check failed");

// next-cycle implication
`define PPM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("projection matrix port check failed");

`endif

### sv/ppm_pkg.sv
package ppm_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int TAN_STAGES  = 16;
    localparam int CORDIC_N    = (TAN_STAGES > 24) ? 24 : TAN_STAGES;
    localparam int ANGLE_SHIFT = 15;
    localparam int QBITS       = 33;
    localparam int WIDE        = 80;

    localparam logic [15:0] FOV_MAX    = 16'd46080;
    localparam logic [31:0] CORDIC_ONE = 32'd268435456;
    localparam logic [30:0] NEAR_RESET = 31'd6554;
    localparam logic [30:0] FAR_RESET  = 31'd6553600;

    localparam logic [QBITS-1:0] POS_LIM = QBITS'(33'h07FFFFFFF);
    localparam logic [QBITS-1:0] NEG_LIM = QBITS'(33'h080000000);

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEIGHT = 2'd1;
    localparam logic [1:0] ST_SAT        = 2'd2;
    localparam logic [1:0] ST_DEPTH      = 2'd3;

    localparam logic REG_NEAR = 1'b0;
    localparam logic REG_FAR  = 1'b1;

    typedef struct packed {
        logic               valid;
        logic               bad_h;
        logic [15:0]        w;
        logic [15:0]        h;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [33:0] z;
    } cord_t;

    typedef struct packed {
        logic [WIDE-1:0]  r;
        logic [WIDE-1:0]  d;
        logic [QBITS-1:0] q;
    } div_t;

    typedef struct packed {
        logic       valid;
        logic       bad_h;
        logic       depth_ok;
        logic [3:0] pre_sat;
    } flags_t;

    // atan(2^-i) in units of 2^-24 degree
    function automatic logic signed [33:0] atan_val(input logic [4:0] i);
        logic signed [33:0] v;
        case (i)
            5'd0:  v = 34'sd754974720;
            5'd1:  v = 34'sd445687602;
            5'd2:  v = 34'sd235489088;
            5'd3:  v = 34'sd119537938;
            5'd4:  v = 34'sd60000934;
            5'd5:  v = 34'sd30029717;
            5'd6:  v = 34'sd15018523;
            5'd7:  v = 34'sd7509719;
            5'd8:  v = 34'sd3754917;
            5'd9:  v = 34'sd1877466;
            5'd10: v = 34'sd938734;
            5'd11: v = 34'sd469367;
            5'd12: v = 34'sd234684;
            5'd13: v = 34'sd117342;
            5'd14: v = 34'sd58671;
            5'd15: v = 34'sd29335;
            5'd16: v = 34'sd14668;
            5'd17: v = 34'sd7334;
            5'd18: v = 34'sd3667;
            5'd19: v = 34'sd1833;
            5'd20: v = 34'sd917;
            5'd21: v = 34'sd458;
            5'd22: v = 34'sd229;
            5'd23: v = 34'sd115;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

endpackage

### sv/ppm_cordic_cell.sv
module ppm_cordic_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic [4:0]      idx,
    input  ppm_pkg::cord_t  cell_in,
    output ppm_pkg::cord_t  cell_out
);

    ppm_pkg::cord_t     step_reg;
    ppm_pkg::cord_t     step_next;
    logic signed [31:0] dx;
    logic signed [31:0] dy;
    logic signed [33:0] at;

    always_comb begin
        dx        = cell_in.y >>> idx;
        dy        = cell_in.x >>> idx;
        at        = ppm_pkg::atan_val(idx);
        step_next = cell_in;
        if (!cell_in.z[33]) begin
            step_next.x = cell_in.x - dx;
            step_next.y = cell_in.y + dy;
            step_next.z = cell_in.z - at;
        end else begin
            step_next.x = cell_in.x + dx;
            step_next.y = cell_in.y - dy;
            step_next.z = cell_in.z + at;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg.valid <= 1'b0;
        end else if (en) begin
            step_reg <= step_next;
        end
    end

    assign cell_out = step_reg;

endmodule

### sv/ppm_prep.sv
module ppm_prep (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        en,
    input  ppm_pkg::cord_t              cord_in,
    input  logic [30:0]                 near_plane,
    input  logic [30:0]                 far_plane,
    output ppm_pkg::div_t [3:0]         lane_init,
    output ppm_pkg::flags_t             flags_out
);

    // stage one: products and plane terms
    logic [29:0]     c_next, s_next;
    logic [29:0]     c_reg, s_reg;
    logic [45:0]     ch_reg, sw_reg;
    logic [31:0]     sum_reg;
    logic [30:0]     diff_reg;
    logic [61:0]     prod_reg;
    ppm_pkg::flags_t f1_reg, f1_next;

    // stage two: divider seeds
    ppm_pkg::div_t [3:0] init_reg, init_next;
    ppm_pkg::flags_t     f2_reg, f2_next;

    function automatic ppm_pkg::div_t seed(input logic [ppm_pkg::WIDE-1:0] n,
                                           input logic [ppm_pkg::WIDE-1:0] d);
        ppm_pkg::div_t t;
        t.r = n;
        t.d = d << (ppm_pkg::QBITS - 1);
        t.q = '0;
        return t;
    endfunction

    function automatic logic early_sat(input logic [ppm_pkg::WIDE-1:0] n,
                                       input logic [ppm_pkg::WIDE-1:0] d);
        return (d == '0) || (n >= (d << ppm_pkg::QBITS));
    endfunction

    always_comb begin
        c_next         = (cord_in.x > 32'sd0) ? cord_in.x[29:0] : 30'd0;
        s_next         = (cord_in.y > 32'sd0) ? cord_in.y[29:0] : 30'd0;
        f1_next        = '0;
        f1_next.valid  = cord_in.valid;
        f1_next.bad_h  = cord_in.bad_h;
        f1_next.depth_ok = far_plane > near_plane;
    end

    logic [ppm_pkg::WIDE-1:0] n_x, n_y, n_ds, n_do, d_x, d_y, d_z;

    always_comb begin
        n_x  = ppm_pkg::WIDE'(ch_reg) << ppm_pkg::FRAC_BITS;
        n_y  = ppm_pkg::WIDE'(c_reg) << ppm_pkg::FRAC_BITS;
        n_ds = ppm_pkg::WIDE'(sum_reg) << ppm_pkg::FRAC_BITS;
        n_do = ppm_pkg::WIDE'(prod_reg) << 1;
        d_x  = ppm_pkg::WIDE'(sw_reg);
        d_y  = ppm_pkg::WIDE'(s_reg);
        d_z  = ppm_pkg::WIDE'(diff_reg);
        init_next[0] = seed(n_x, d_x);
        init_next[1] = seed(n_y, d_y);
        init_next[2] = seed(n_ds, d_z);
        init_next[3] = seed(n_do, d_z);
        f2_next            = f1_reg;
        f2_next.pre_sat[0] = early_sat(n_x, d_x);
        f2_next.pre_sat[1] = early_sat(n_y, d_y);
        f2_next.pre_sat[2] = early_sat(n_ds, d_z);
        f2_next.pre_sat[3] = early_sat(n_do, d_z);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_reg.valid <= 1'b0;
            f2_reg.valid <= 1'b0;
        end else if (en) begin
            c_reg    <= c_next;
            s_reg    <= s_next;
            ch_reg   <= c_next * cord_in.h;
            sw_reg   <= s_next * cord_in.w;
            sum_reg  <= 32'(far_plane) + 32'(near_plane);
            diff_reg <= far_plane - near_plane;
            prod_reg <= far_plane * near_plane;
            f1_reg   <= f1_next;
            init_reg <= init_next;
            f2_reg   <= f2_next;
        end
    end

    assign lane_init = init_reg;
    assign flags_out = f2_reg;

endmodule

### sv/ppm_div_cell.sv
module ppm_div_cell (
    input  logic           aclk,
    input  logic           en,
    input  ppm_pkg::div_t  cell_in,
    output ppm_pkg::div_t  cell_out
);

    ppm_pkg::div_t step_reg;
    ppm_pkg::div_t step_next;

    always_comb begin
        step_next   = cell_in;
        step_next.d = cell_in.d >> 1;
        if (cell_in.r >= cell_in.d) begin
            step_next.r = cell_in.r - cell_in.d;
            step_next.q = {cell_in.q[ppm_pkg::QBITS-2:0], 1'b1};
        end else begin
            step_next.q = {cell_in.q[ppm_pkg::QBITS-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            step_reg <= step_next;
        end
    end

    assign cell_out = step_reg;

endmodule

### sv/perspective_projection_matrix_unit.sv
// path from request to result: tangent cells, product and seed registers, divider cells, result register
// throughput: one request per cycle while results are taken, set by the one-cell-per-step tangent and divider chains
// a stalled result holds the whole chain until it is taken
// reset (aresetn low, synchronous): valid bits clear, near 0.1 and far 100 in Q16.16
module perspective_projection_matrix_unit (
    input  logic               aclk,
    input  logic               aresetn,
    // camera request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_screen_width,
    input  logic [15:0]        s_screen_height,
    input  logic [15:0]        s_fov_degrees,
    // matrix result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [1:0]         m_status,
    output logic signed [31:0] m_x_scale,
    output logic signed [31:0] m_y_scale,
    output logic signed [31:0] m_depth_scale,
    output logic signed [31:0] m_depth_offset,
    // register port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int CN = ppm_pkg::CORDIC_N;
    localparam int QB = ppm_pkg::QBITS;

    // whole chain moves together whenever the result slot is free or being taken
    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // plane registers
    logic [30:0] near_reg, far_reg;
    logic        wr_en;
    assign wr_en  = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            near_reg <= ppm_pkg::NEAR_RESET;
            far_reg  <= ppm_pkg::FAR_RESET;
        end else if (wr_en && paddr[1:0] == 2'b00) begin
            case (paddr[2])
                ppm_pkg::REG_NEAR: near_reg <= pwdata[30:0];
                ppm_pkg::REG_FAR:  far_reg  <= pwdata[30:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            ppm_pkg::REG_NEAR: prdata = {1'b0, near_reg};
            ppm_pkg::REG_FAR:  prdata = {1'b0, far_reg};
            default:           prdata = '0;
        endcase
    end

    // tangent chain: angle in 2^-24 degree, fov clamped to 180
    ppm_pkg::cord_t cord [CN+1];
    logic [15:0]    fov_c;

    always_comb begin
        fov_c         = (s_fov_degrees > ppm_pkg::FOV_MAX) ? ppm_pkg::FOV_MAX : s_fov_degrees;
        cord[0].valid = s_valid;
        cord[0].bad_h = (s_screen_height == 16'd0);
        cord[0].w     = s_screen_width;
        cord[0].h     = s_screen_height;
        cord[0].x     = ppm_pkg::CORDIC_ONE;
        cord[0].y     = 32'sd0;
        cord[0].z     = 34'(fov_c) << ppm_pkg::ANGLE_SHIFT;
    end

    genvar gi, gl;
    generate
        for (gi = 0; gi < CN; gi++) begin : g_cordic
            ppm_cordic_cell u_cell (
                .aclk    (aclk),
                .aresetn (aresetn),
                .en      (en),
                .idx     (5'(gi)),
                .cell_in (cord[gi]),
                .cell_out(cord[gi+1])
            );
        end
    endgenerate

    // products, plane terms and divider seeds
    ppm_pkg::div_t [3:0] lane_init;
    ppm_pkg::flags_t     flags_init;

    ppm_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .cord_in   (cord[CN]),
        .near_plane(near_reg),
        .far_plane (far_reg),
        .lane_init (lane_init),
        .flags_out (flags_init)
    );

    // four divider lanes, one quotient bit per cell, flags ride alongside
    ppm_pkg::div_t   lane [4][QB+1];
    ppm_pkg::flags_t flag_reg [QB];

    generate
        for (gl = 0; gl < 4; gl++) begin : g_lane
            assign lane[gl][0] = lane_init[gl];
            for (gi = 0; gi < QB; gi++) begin : g_bit
                ppm_div_cell u_cell (
                    .aclk    (aclk),
                    .en      (en),
                    .cell_in (lane[gl][gi]),
                    .cell_out(lane[gl][gi+1])
                );
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QB; k++) begin
                flag_reg[k].valid <= 1'b0;
            end
        end else if (en) begin
            flag_reg[0] <= flags_init;
            for (int k = 1; k < QB; k++) begin
                flag_reg[k] <= flag_reg[k-1];
            end
        end
    end

    // result formatting: saturate, negate depth terms, pick status, zero terms on errors
    ppm_pkg::flags_t fl;
    logic [3:0]      sat;
    logic [QB-1:0]   mag_ds, mag_do;
    logic [1:0]      status_next;
    logic [31:0]     xs_next, ys_next, ds_next, do_next;

    always_comb begin
        fl     = flag_reg[QB-1];
        sat[0] = fl.pre_sat[0] || (lane[0][QB].q > ppm_pkg::POS_LIM);
        sat[1] = fl.pre_sat[1] || (lane[1][QB].q > ppm_pkg::POS_LIM);
        sat[2] = fl.pre_sat[2] || (lane[2][QB].q > ppm_pkg::NEG_LIM);
        sat[3] = fl.pre_sat[3] || (lane[3][QB].q > ppm_pkg::NEG_LIM);
        mag_ds = sat[2] ? ppm_pkg::NEG_LIM : lane[2][QB].q;
        mag_do = sat[3] ? ppm_pkg::NEG_LIM : lane[3][QB].q;
        xs_next = sat[0] ? ppm_pkg::POS_LIM[31:0] : lane[0][QB].q[31:0];
        ys_next = sat[1] ? ppm_pkg::POS_LIM[31:0] : lane[1][QB].q[31:0];
        ds_next = 32'd0 - mag_ds[31:0];
        do_next = 32'd0 - mag_do[31:0];
        if (fl.bad_h) begin
            status_next = ppm_pkg::ST_BAD_HEIGHT;
            xs_next = '0;
            ys_next = '0;
            ds_next = '0;
            do_next = '0;
        end else if (!fl.depth_ok) begin
            status_next = ppm_pkg::ST_DEPTH;
            ds_next = '0;
            do_next = '0;
        end else if (|sat) begin
            status_next = ppm_pkg::ST_SAT;
        end else begin
            status_next = ppm_pkg::ST_OK;
        end
    end

    logic        m_valid_reg;
    logic [1:0]  m_status_reg;
    logic [31:0] m_xs_reg, m_ys_reg, m_ds_reg, m_do_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg  <= fl.valid;
            m_status_reg <= status_next;
            m_xs_reg     <= xs_next;
            m_ys_reg     <= ys_next;
            m_ds_reg     <= ds_next;
            m_do_reg     <= do_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_x_scale      = m_xs_reg;
    assign m_y_scale      = m_ys_reg;
    assign m_depth_scale  = m_ds_reg;
    assign m_depth_offset = m_do_reg;

endmodule

### sv/ppm_checker.sv
`include "perspective_projection_matrix_unit_macros.svh"

module ppm_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [1:0]         m_status,
    input logic signed [31:0] m_x_scale,
    input logic signed [31:0] m_y_scale,
    input logic signed [31:0] m_depth_scale,
    input logic signed [31:0] m_depth_offset
);

    // a result that waits stays offered
    `PPM_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid)

    // zero height gives an all-zero matrix
    `PPM_ASSERT_SAME(a_bad_h, aclk, aresetn, m_valid && m_status == ppm_pkg::ST_BAD_HEIGHT, m_x_scale == 32'sd0 && m_y_scale == 32'sd0 && m_depth_scale == 32'sd0 && m_depth_offset == 32'sd0)

    // broken planes give zero depth terms
    `PPM_ASSERT_SAME(a_depth, aclk, aresetn, m_valid && m_status == ppm_pkg::ST_DEPTH, m_depth_scale == 32'sd0 && m_depth_offset == 32'sd0)

    // a healthy depth scale is never positive
    `PPM_ASSERT_SAME(a_ds_sign, aclk, aresetn, m_valid && (m_status == ppm_pkg::ST_OK || m_status == ppm_pkg::ST_SAT), m_depth_scale <= 32'sd0)

endmodule

bind perspective_projection_matrix_unit ppm_checker u_ppm_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_status      (m_status),
    .m_x_scale     (m_x_scale),
    .m_y_scale     (m_y_scale),
    .m_depth_scale (m_depth_scale),
    .m_depth_offset(m_depth_offset)
);
